[rtl/core/btd_pkg.sv]
// Shared constants, types and lookup tables of the BASIC token detokenizer.
`default_nettype none
package btd_pkg;

	localparam int BYTE_W   = 8;
	localparam int KW_COUNT = 84;
	localparam int KW_IDX_W = 7;
	localparam int POS_W    = 4;

	localparam logic [7:0] KW_FIRST  = 8'h80;
	localparam logic [7:0] KW_LAST   = 8'hD3;
	localparam logic [7:0] LEAD_MARK = 8'hFF;
	localparam logic [7:0] BYTE_NUL  = 8'h00;

	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_UPPER = 8'h41;

	// parser phases
	localparam logic [2:0] PH_START   = 3'd0;
	localparam logic [2:0] PH_LINK_LO = 3'd1;
	localparam logic [2:0] PH_LINK_HI = 3'd2;
	localparam logic [2:0] PH_NUM_LO  = 3'd3;
	localparam logic [2:0] PH_NUM_HI  = 3'd4;
	localparam logic [2:0] PH_BODY    = 3'd5;
	localparam logic [2:0] PH_DONE    = 3'd6;

	// expansion job kinds
	localparam logic [2:0] JK_NL   = 3'd0;
	localparam logic [2:0] JK_CHAR = 3'd1;
	localparam logic [2:0] JK_KW   = 3'd2;
	localparam logic [2:0] JK_UNK  = 3'd3;
	localparam logic [2:0] JK_NUM  = 3'd4;

	// expander parts
	localparam logic [1:0] PART_MAIN  = 2'd0;
	localparam logic [1:0] PART_SPACE = 2'd1;
	localparam logic [1:0] PART_NL    = 2'd2;

	localparam logic [POS_W-1:0] UNK_LAST = 4'd11;

	typedef struct packed {
		logic        valid;
		logic [2:0]  kind;
		logic [15:0] value;     // number, byte, or keyword index
		logic [2:0]  first_pos; // top decimal digit, or keyword length - 1
		logic        add_nl;
	} job_t;

	// keyword text, right-justified: character p of a keyword of length n
	// sits in byte n-1-p
	localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
		"", "END", "FOR", "NEXT", "DATA", "INPUT", "DIM", "READ",
		"LET", "GOTO", "RUN", "IF", "RESTORE", "GOSUB", "RETURN", "REM",
		"", "PRINT", "ON", "", "", "", "DEF", "POKE",
		"PRINT#", "SECURE", "CLS", "WIDTH", "ELSE", "TRON", "TROFF", "SWAP",
		"ERASE", "EDIT", "ERROR", "RESUME", "PLAY", "ON/ERROR", "LIST", "NEW",
		"ON/KEY", "ON/PLAY", "ON/TIMER", "OPTION", "ENVIRON", "SYSTEM", "KEY", "SHELL",
		"CLOSE", "LOAD", "MERGE", "SAVE", "COLOR", "", "", "OPEN",
		"FIELD", "GET", "PUT", "SEEK", "FILES", "KILL", "CHDIR", "MKDIR",
		"RMDIR", "NAME", "LINE", "CIRCLE", "PSET", "PRESET", "SCREEN", "PAINT",
		"SOUND", "", "", "", "USING", "THEN", "TO", "STEP",
		"DIR", "SETATTR", "LOCK", "UNLOCK"
	};

	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd0, 4'd3, 4'd3, 4'd4, 4'd4, 4'd5, 4'd3, 4'd4,
		4'd3, 4'd4, 4'd3, 4'd2, 4'd7, 4'd5, 4'd6, 4'd3,
		4'd0, 4'd5, 4'd2, 4'd0, 4'd0, 4'd0, 4'd3, 4'd4,
		4'd6, 4'd6, 4'd3, 4'd5, 4'd4, 4'd4, 4'd5, 4'd4,
		4'd5, 4'd4, 4'd5, 4'd6, 4'd4, 4'd8, 4'd4, 4'd3,
		4'd6, 4'd7, 4'd8, 4'd6, 4'd7, 4'd6, 4'd3, 4'd5,
		4'd5, 4'd4, 4'd5, 4'd4, 4'd5, 4'd0, 4'd0, 4'd4,
		4'd5, 4'd3, 4'd3, 4'd4, 4'd5, 4'd4, 4'd5, 4'd5,
		4'd5, 4'd4, 4'd4, 4'd6, 4'd4, 4'd6, 4'd6, 4'd5,
		4'd5, 4'd0, 4'd0, 4'd0, 4'd5, 4'd4, 4'd2, 4'd4,
		4'd3, 4'd7, 4'd4, 4'd6
	};

	function automatic logic [16:0] pow10(input logic [2:0] k);
		logic [16:0] p;
		case (k)
			3'd0: p = 17'd1;
			3'd1: p = 17'd10;
			3'd2: p = 17'd100;
			3'd3: p = 17'd1000;
			3'd4: p = 17'd10000;
			default: p = 17'd1;
		endcase
		return p;
	endfunction

	function automatic logic [16:0] dec_step(input logic [2:0] k, input logic [3:0] d);
		return 17'(pow10(k) * d);
	endfunction

	// index of the most significant decimal digit
	function automatic logic [2:0] num_top(input logic [15:0] v);
		logic [2:0] t;
		if (v >= 16'd10000)     t = 3'd4;
		else if (v >= 16'd1000) t = 3'd3;
		else if (v >= 16'd100)  t = 3'd2;
		else if (v >= 16'd10)   t = 3'd1;
		else                    t = 3'd0;
		return t;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		return (n < 4'd10) ? 8'(CH_ZERO + n) : 8'(CH_UPPER + n - 4'd10);
	endfunction

	// characters of the unknown-token form "[TOKEN:0xHH]"
	function automatic logic [7:0] unk_char(input logic [POS_W-1:0] p, input logic [7:0] b);
		logic [7:0] c;
		case (p)
			4'd0:    c = "[";
			4'd1:    c = "T";
			4'd2:    c = "O";
			4'd3:    c = "K";
			4'd4:    c = "E";
			4'd5:    c = "N";
			4'd6:    c = ":";
			4'd7:    c = "0";
			4'd8:    c = "x";
			4'd9:    c = hex_char(b[7:4]);
			4'd10:   c = hex_char(b[3:0]);
			default: c = "]";
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

[rtl/core/btd_ifs.sv]
// Valid/ready stream interfaces for the detokenizer's byte input and character output.
`default_nettype none
interface btd_byte_if;
	import btd_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              end_of_file;
	modport source (output valid, data_byte, end_of_file, input ready);
	modport sink (input valid, data_byte, end_of_file, output ready);
endinterface

interface btd_char_if;
	import btd_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] text_char;
	logic              run_last;
	modport source (output valid, text_char, run_last, input ready);
	modport sink (input valid, text_char, run_last, output ready);
endinterface
`default_nettype wire

[rtl/core/btd_expander.sv]
// Expands one job into a run of characters, one per cycle while char_out is not stalled, with a keyword ROM.
`default_nettype none
module btd_expander (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire btd_pkg::job_t job,
	output logic               job_ready,
	btd_char_if.source         char_out
);
	import btd_pkg::*;

	logic             busy_q;
	logic [2:0]       kind_q;
	logic [15:0]      val_q;
	logic [POS_W-1:0] pos_q;
	logic [1:0]       part_q;
	logic             nl_q;

	logic             valid_s2;
	logic             rom_sel_s2;
	logic [7:0]       char_s2;
	logic [7:0]       rom_s2;
	logic             last_s2;

	logic        adv, step, finishing, main_end, last_now, sel_rom;
	logic [7:0]  ch;
	logic [3:0]  digit;
	logic [16:0] sub;
	logic [15:0] rem_next;

	assign adv = !valid_s2 || char_out.ready;
	assign step = busy_q && adv;

	// current decimal digit: largest multiple of the place value that fits
	always_comb begin
		digit = 4'd0;
		sub = 17'd0;
		for (int d = 1; d <= 9; d++) begin
			if ({1'b0, val_q} >= dec_step(pos_q[2:0], 4'(d))) begin
				digit = 4'(d);
				sub = dec_step(pos_q[2:0], 4'(d));
			end
		end
		rem_next = 16'({1'b0, val_q} - sub);
	end

	always_comb begin
		sel_rom = 1'b0;
		ch = CH_NL;
		main_end = 1'b1;
		case (part_q)
			PART_MAIN: begin
				case (kind_q)
					JK_NUM: begin
						ch = 8'(CH_ZERO + digit);
						main_end = (pos_q == '0);
					end
					JK_KW: begin
						sel_rom = 1'b1;
						main_end = (pos_q == '0);
					end
					JK_UNK: begin
						ch = unk_char(pos_q, val_q[7:0]);
						main_end = (pos_q == UNK_LAST);
					end
					JK_CHAR: ch = val_q[7:0];
					default: ch = CH_NL;
				endcase
			end
			PART_SPACE: ch = CH_SPACE;
			default: ch = CH_NL;
		endcase
		last_now = (part_q == PART_NL)
			|| (part_q == PART_SPACE && !nl_q)
			|| (part_q == PART_MAIN && main_end && kind_q != JK_NUM && !nl_q);
	end

	assign finishing = step && last_now;
	assign job_ready = !busy_q || finishing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			part_q <= PART_MAIN;
		end else if (job.valid && job_ready) begin
			busy_q <= 1'b1;
			part_q <= (job.kind == JK_NL) ? PART_NL : PART_MAIN;
		end else if (finishing) begin
			busy_q <= 1'b0;
		end else if (step) begin
			if (part_q == PART_MAIN && main_end)
				part_q <= (kind_q == JK_NUM) ? PART_SPACE : PART_NL;
			else if (part_q == PART_SPACE)
				part_q <= PART_NL;
		end
	end

	always_ff @(posedge clk) begin
		if (job.valid && job_ready) begin
			kind_q <= job.kind;
			val_q <= job.value;
			nl_q <= job.add_nl;
			pos_q <= (job.kind == JK_UNK) ? '0 : POS_W'(job.first_pos);
		end else if (step && part_q == PART_MAIN && !main_end) begin
			case (kind_q)
				JK_NUM: begin
					pos_q <= pos_q - 1'b1;
					val_q <= rem_next;
				end
				JK_KW: pos_q <= pos_q - 1'b1;
				JK_UNK: pos_q <= pos_q + 1'b1;
				default: pos_q <= pos_q;
			endcase
		end
	end

	// output register; keyword ROM read lands in the same stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (adv)
			valid_s2 <= step;
	end

	always_ff @(posedge clk) begin
		if (adv && step) begin
			rom_sel_s2 <= sel_rom;
			char_s2 <= ch;
			last_s2 <= last_now;
			if (sel_rom)
				rom_s2 <= KW_TEXT[val_q[KW_IDX_W-1:0]][{pos_q[2:0], 3'b000} +: 8];
		end
	end

	assign char_out.valid = valid_s2;
	assign char_out.text_char = rom_sel_s2 ? rom_s2 : char_s2;
	assign char_out.run_last = last_s2;

	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		job.valid && job_ready |=> busy_q)
		else $error("expander idle after job load");

	a_unk_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && kind_q == JK_UNK && part_q == PART_MAIN |-> pos_q <= UNK_LAST)
		else $error("unknown-token position out of range");

	a_num_digit: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && kind_q == JK_NUM && part_q == PART_MAIN
		|-> {1'b0, val_q} < dec_step(pos_q[2:0], 4'd10))
		else $error("line number remainder exceeds place value");

	a_kw_pos: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && kind_q == JK_KW && part_q == PART_MAIN
		|-> {1'b0, pos_q} < {1'b0, KW_LEN[val_q[KW_IDX_W-1:0]]})
		else $error("keyword position past keyword length");

endmodule
`default_nettype wire

[rtl/core/basic_token_detokenizer.sv]
// Top level of the BASIC token detokenizer: file parser feeding the character expander.
// Usage:
//   byte_in carries one byte of a tokenized program file per transfer, with
//   end_of_file set on the final byte. char_out carries listing characters,
//   one per transfer; run_last marks the last character caused by one byte.
//   Link-word and line-number low bytes produce no characters.
// Flow and throughput:
//   A byte is parsed in the cycle of its transfer and its job is registered in
//   the expander's state at that edge; each character then passes through the
//   output register before it can transfer on char_out. The expander emits one
//   character per cycle while char_out is not stalled. A byte yields 1 or 2
//   characters as a plain body byte, 2 to 9 as a keyword, 12 or 13 as an
//   unknown token, 2 to 7 as a line number. Bytes that yield nothing are taken
//   whenever the expander is ready. The next byte is taken in the cycle the
//   previous run's last character is issued.
// Reset:
//   arst_n clears the parser to start of file and empties the output stage.
// Stalls:
//   When char_out.ready is low the output register holds its character, the
//   expander waits, and byte_in.ready stays low while a run is unfinished.
`default_nettype none
module basic_token_detokenizer (
	input  wire logic clk,
	input  wire logic arst_n,
	btd_byte_if.sink  byte_in,
	btd_char_if.source char_out
);
	import btd_pkg::*;

	logic [2:0] phase_q, phase_d;
	logic [7:0] held_q, held_d;
	job_t       job;
	logic       job_ready;
	logic       acc;
	logic [7:0] b;
	logic       eof;
	logic [KW_IDX_W-1:0] tok;

	assign acc = byte_in.valid && byte_in.ready;
	assign byte_in.ready = job_ready;
	assign b = byte_in.data_byte;
	assign eof = byte_in.end_of_file;
	assign tok = b[KW_IDX_W-1:0];

	always_comb begin
		phase_d = phase_q;
		held_d = held_q;
		job = '0;
		job.add_nl = eof;
		case (phase_q)
			PH_START: begin
				if (b == LEAD_MARK) begin
					phase_d = PH_LINK_LO;
				end else begin
					held_d = b;
					phase_d = PH_LINK_HI;
				end
			end
			PH_LINK_LO: begin
				held_d = b;
				phase_d = PH_LINK_HI;
			end
			PH_LINK_HI: begin
				phase_d = (held_q == BYTE_NUL && b == BYTE_NUL) ? PH_DONE : PH_NUM_LO;
			end
			PH_NUM_LO: begin
				held_d = b;
				phase_d = PH_NUM_HI;
			end
			PH_NUM_HI: begin
				job.valid = acc;
				job.kind = JK_NUM;
				job.value = {b, held_q};
				job.first_pos = num_top({b, held_q});
				phase_d = PH_BODY;
			end
			PH_BODY: begin
				job.valid = acc;
				if (b == BYTE_NUL) begin
					job.kind = JK_NL;
					job.add_nl = 1'b0;
					phase_d = PH_LINK_LO;
				end else if (b < KW_FIRST) begin
					job.kind = JK_CHAR;
					job.value = {8'h00, b};
				end else if (b <= KW_LAST && KW_LEN[tok] != 4'd0) begin
					job.kind = JK_KW;
					job.value = 16'(tok);
					job.first_pos = 3'(KW_LEN[tok] - 4'd1);
				end else begin
					job.kind = JK_UNK;
					job.value = {8'h00, b};
				end
			end
			default: phase_d = PH_DONE;
		endcase
		if (eof)
			phase_d = PH_START;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			held_q <= 8'h00;
		end else if (acc) begin
			phase_q <= phase_d;
			held_q <= held_d;
		end
	end

	btd_expander u_expander (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job),
		.job_ready (job_ready),
		.char_out  (char_out)
	);

	a_eof_restart: assert property (@(posedge clk) disable iff (!arst_n)
		acc && eof |=> phase_q == PH_START)
		else $error("parser did not return to start of file");

	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		acc && phase_q == PH_DONE |-> !job.valid)
		else $error("job issued after program end");

	a_job_taken: assert property (@(posedge clk) disable iff (!arst_n)
		job.valid |-> job_ready)
		else $error("job issued while expander busy");

endmodule
`default_nettype wire
